// ===== rtl/core/ilcs_pkg.sv =====
package ilcs_pkg;

    localparam int unsigned CodeWidth  = 12;
    localparam int unsigned ValueWidth = 48;
    localparam int unsigned ValueBytes = ValueWidth / 8;

    // header bit 12 marks a counted item
    localparam int unsigned CountedBit = 12;

    localparam logic [2:0] CaptureCounted = 3'd6;
    localparam logic [2:0] CapturePlain   = 3'd4;
    localparam logic [15:0] PlainSkip     = 16'd4;

    typedef enum logic [6:0] {
        PH_HDR_LO  = 7'b0000001,
        PH_HDR_HI  = 7'b0000010,
        PH_LEN_LO  = 7'b0000100,
        PH_LEN_HI  = 7'b0001000,
        PH_SKIP    = 7'b0010000,
        PH_CAPTURE = 7'b0100000,
        PH_DONE    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic                  found;
        logic                  counted;
        logic [ValueWidth-1:0] value;
    } result_t;

endpackage

// ===== rtl/core/ilcs_parser.sv =====
module ilcs_parser
    import ilcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CodeWidth-1:0] search_code,
    input  logic                 beat_accept,
    input  logic [7:0]           beat_byte,
    input  logic                 beat_last,
    output result_t              result
);

    phase_t                phase_reg, phase_next;
    logic [7:0]            hdr_lo_reg, hdr_lo_next;
    logic [15:0]           skip_reg, skip_next;
    logic [2:0]            idx_reg, idx_next;
    logic [ValueWidth-1:0] cap_reg, cap_next;
    logic                  found_reg, found_next;
    logic                  counted_reg, counted_next;

    logic [15:0] header;
    logic [15:0] length;
    logic [15:0] skip_dec;
    logic [2:0]  limit;
    logic        hdr_match;

    assign header    = {beat_byte, hdr_lo_reg};
    assign length    = {beat_byte, skip_reg[7:0]};
    assign skip_dec  = (skip_reg != 16'd0) ? skip_reg - 16'd1 : 16'd0;
    assign limit     = counted_reg ? CaptureCounted : CapturePlain;
    assign hdr_match = (header[CodeWidth-1:0] == search_code);

    always_comb begin
        phase_next   = phase_reg;
        hdr_lo_next  = hdr_lo_reg;
        skip_next    = skip_reg;
        idx_next     = idx_reg;
        cap_next     = cap_reg;
        found_next   = found_reg;
        counted_next = counted_reg;
        unique case (phase_reg)
            PH_HDR_LO: begin
                hdr_lo_next = beat_byte;
                phase_next  = PH_HDR_HI;
                // buffer ends mid-header: high byte reads as zero
                if (beat_last && ({4'd0, beat_byte} == search_code)) begin
                    found_next = 1'b1;
                end
            end
            PH_HDR_HI: begin
                if (hdr_match) begin
                    found_next   = 1'b1;
                    counted_next = header[CountedBit];
                end
                if (header[CountedBit]) begin
                    phase_next = PH_LEN_LO;
                end else if (hdr_match) begin
                    idx_next   = 3'd0;
                    phase_next = PH_CAPTURE;
                end else begin
                    skip_next  = PlainSkip;
                    phase_next = PH_SKIP;
                end
            end
            PH_LEN_LO: begin
                skip_next  = {8'd0, beat_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                skip_next = length;
                if (found_reg) begin
                    idx_next   = 3'd0;
                    phase_next = PH_CAPTURE;
                end else if (length == 16'd0) begin
                    phase_next = PH_HDR_LO;
                end else begin
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0) begin
                    phase_next = PH_HDR_LO;
                end
            end
            PH_CAPTURE: begin
                if (idx_reg < limit) begin
                    for (int k = 0; k < ValueBytes; k++) begin
                        if (idx_reg == 3'(k)) begin
                            cap_next[8*k +: 8] = beat_byte;
                        end
                    end
                    idx_next = idx_reg + 3'd1;
                end
                if (idx_next >= limit) begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_HDR_LO;
            end
        endcase
    end

    // result as it stands after this beat
    assign result.found   = found_next;
    assign result.counted = counted_next;
    assign result.value   = cap_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_accept && beat_last)) begin
            phase_reg   <= PH_HDR_LO;
            hdr_lo_reg  <= '0;
            skip_reg    <= '0;
            idx_reg     <= '0;
            cap_reg     <= '0;
            found_reg   <= 1'b0;
            counted_reg <= 1'b0;
        end else if (beat_accept) begin
            phase_reg   <= phase_next;
            hdr_lo_reg  <= hdr_lo_next;
            skip_reg    <= skip_next;
            idx_reg     <= idx_next;
            cap_reg     <= cap_next;
            found_reg   <= found_next;
            counted_reg <= counted_next;
        end
    end

endmodule

// ===== rtl/core/item_list_code_search_top.sv =====
// Output: the result beat appears in the cycle after the beat marked tlast is taken.
// Throughput: one byte beat per cycle unless a held result waits on m_tready; parser
//   state updates once per byte; the output register frees as soon as m_tready is seen.
// Reset: aresetn is synchronous, active low; it clears the parser, the output
//   valid flag and search_code (to code 0); the held output data is not reset.
module item_list_code_search_top
    import ilcs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // search code write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CodeWidth-1:0]  cfg_data,     // search_code
    // byte stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,      // [7:0] data_byte
    input  logic                  s_tlast,      // last_byte
    // result out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ValueWidth-1:0] m_tdata,      // [47:0] item_value
    output logic [1:0]            m_tuser       // [0] found, [1] counted_item
);

    logic [CodeWidth-1:0] code_reg;
    logic                 m_valid_reg;
    result_t              out_reg;
    result_t              parse_result;
    logic                 s_beat;
    logic                 m_beat;

    assign cfg_ready = 1'b1;

    // a waiting result only blocks input if nobody is taking it this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign s_beat   = s_tvalid && s_tready;
    assign m_beat   = m_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= '0;
        end else if (cfg_valid) begin
            code_reg <= cfg_data;
        end
    end

    ilcs_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .search_code (code_reg),
        .beat_accept (s_beat),
        .beat_byte   (s_tdata),
        .beat_last   (s_tlast),
        .result      (parse_result)
    );

    // output register, loaded on the last byte of each buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_beat) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && s_tlast) begin
            out_reg <= parse_result;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_reg.value;
    assign m_tuser[0] = out_reg.found;
    assign m_tuser[1] = out_reg.counted;

    a_counted_needs_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
        else $error("counted flag without a match");

    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("nonzero value on a miss");

    a_plain_is_32bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[47:32] == 16'd0))
        else $error("plain item value wider than 32 bits");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after last byte");

endmodule
